### hdl/lprd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lprd_pkg;

  typedef enum logic [1:0] {
    KIND_ARG_BYTE  = 2'd0,
    KIND_EMPTY_ARG = 2'd1,
    KIND_COMPLETE  = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_TOO_LONG   = 3'd0,
    ERR_SHORT_BODY = 3'd1,
    ERR_TOO_MANY   = 3'd2,
    ERR_OVERRUN    = 3'd3,
    ERR_TRAILING   = 3'd4
  } err_e;

  // configuration register indexes
  localparam logic CfgMaxFrame = 1'b0;
  localparam logic CfgMaxArgs  = 1'b1;

  localparam int FrameW = 13;
  localparam int ArgW   = 11;

  localparam logic [FrameW-1:0] MaxFrameReset = 13'd4096;
  localparam logic [ArgW-1:0]   MaxArgsReset  = 11'd1024;

  // result queue: one request yields up to two results
  localparam int ResDepth = 4;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       new_connection;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic [9:0]  argument_index;
    logic [7:0]  payload_byte;
    logic        last_in_argument;
    logic [10:0] argument_count;
    err_e        error_code;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

endpackage

`default_nettype wire

### hdl/lprd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module lprd_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          take_i,
  input  wire lprd_pkg::req_t                req_i,
  input  wire logic [lprd_pkg::FrameW-1:0]   lim_frame_i,
  input  wire logic [lprd_pkg::ArgW-1:0]     lim_args_i,
  output lprd_pkg::res_pair_t                res_o
);
  import lprd_pkg::*;

  localparam logic [2:0] PhLength = 3'd0;
  localparam logic [2:0] PhCount  = 3'd1;
  localparam logic [2:0] PhArglen = 3'd2;
  localparam logic [2:0] PhData   = 3'd3;
  localparam logic [2:0] PhHalt   = 3'd4;

  logic [2:0]        ph_q, ph_d, s_ph;
  logic [1:0]        cnt_q, cnt_d, s_cnt;
  logic [23:0]       sh_q, sh_d, s_sh;
  logic [FrameW-1:0] fl_q, fl_d, s_fl;
  logic [FrameW-1:0] bp_q, bp_d, s_bp;
  logic [ArgW-1:0]   ar_q, ar_d, s_ar;
  logic [ArgW-1:0]   cur_q, cur_d, s_cur;
  logic [FrameW-1:0] abl_q, abl_d, s_abl;

  logic [31:0]       v;
  logic              hdr_done;
  logic              do_next;
  logic              prim_v, sec_v;
  res_t              prim, sec;
  logic [FrameW-1:0] room_left;

  always_comb begin
    // new connection clears parse state before the byte is used
    if (req_i.new_connection) begin
      s_ph  = PhLength;
      s_cnt = '0;
      s_sh  = '0;
      s_fl  = '0;
      s_bp  = '0;
      s_ar  = '0;
      s_cur = '0;
      s_abl = '0;
    end else begin
      s_ph  = ph_q;
      s_cnt = cnt_q;
      s_sh  = sh_q;
      s_fl  = fl_q;
      s_bp  = bp_q;
      s_ar  = ar_q;
      s_cur = cur_q;
      s_abl = abl_q;
    end

    ph_d   = s_ph;
    cnt_d  = s_cnt;
    sh_d   = s_sh;
    fl_d   = s_fl;
    bp_d   = s_bp;
    ar_d   = s_ar;
    cur_d  = s_cur;
    abl_d  = s_abl;
    do_next = 1'b0;
    prim_v = 1'b0;
    prim   = '0;
    sec_v  = 1'b0;
    sec    = '0;
    room_left = '0;

    v        = {req_i.stream_byte, s_sh};
    hdr_done = (s_cnt == 2'd3);

    // little-endian header collection, shared by the three header phases
    if (s_ph == PhLength || s_ph == PhCount || s_ph == PhArglen) begin
      cnt_d = s_cnt + 2'd1;
      case (s_cnt)
        2'd0:    sh_d[7:0]   = req_i.stream_byte;
        2'd1:    sh_d[15:8]  = req_i.stream_byte;
        2'd2:    sh_d[23:16] = req_i.stream_byte;
        default: sh_d        = s_sh;
      endcase
    end

    unique case (s_ph)
      PhLength: begin
        if (hdr_done) begin
          if (v > {19'd0, lim_frame_i}) begin
            prim_v = 1'b1;
            prim.kind = KIND_ERROR;
            prim.error_code = ERR_TOO_LONG;
            ph_d = PhHalt;
          end else if (v < 32'd4) begin
            prim_v = 1'b1;
            prim.kind = KIND_ERROR;
            prim.error_code = ERR_SHORT_BODY;
            ph_d = PhHalt;
          end else begin
            fl_d = v[FrameW-1:0];
            bp_d = '0;
            ph_d = PhCount;
          end
        end
      end
      PhCount: begin
        bp_d = s_bp + 1'b1;
        if (hdr_done) begin
          if (v > {21'd0, lim_args_i}) begin
            prim_v = 1'b1;
            prim.kind = KIND_ERROR;
            prim.error_code = ERR_TOO_MANY;
            ph_d = PhHalt;
          end else begin
            ar_d  = v[ArgW-1:0];
            cur_d = '0;
            do_next = 1'b1;
          end
        end
      end
      PhArglen: begin
        bp_d = s_bp + 1'b1;
        if (hdr_done) begin
          if (v > {19'd0, s_fl - bp_d}) begin
            prim_v = 1'b1;
            prim.kind = KIND_ERROR;
            prim.error_code = ERR_OVERRUN;
            ph_d = PhHalt;
          end else if (v == 32'd0) begin
            prim_v = 1'b1;
            prim.kind = KIND_EMPTY_ARG;
            prim.argument_index = s_cur[9:0];
            cur_d = s_cur + 1'b1;
            ar_d  = s_ar - 1'b1;
            do_next = 1'b1;
          end else begin
            abl_d = v[FrameW-1:0];
            ph_d  = PhData;
          end
        end
      end
      PhData: begin
        bp_d  = s_bp + 1'b1;
        abl_d = s_abl - 1'b1;
        prim_v = 1'b1;
        prim.kind = KIND_ARG_BYTE;
        prim.argument_index = s_cur[9:0];
        prim.payload_byte = req_i.stream_byte;
        prim.last_in_argument = (abl_d == '0);
        if (abl_d == '0) begin
          cur_d = s_cur + 1'b1;
          ar_d  = s_ar - 1'b1;
          do_next = 1'b1;
        end
      end
      default: begin
        // halted: the byte is dropped
      end
    endcase

    // what follows the count or the end of an argument
    if (do_next) begin
      room_left = fl_d - bp_d;
      if (ar_d == '0) begin
        sec_v = 1'b1;
        if (bp_d == fl_d) begin
          sec.kind = KIND_COMPLETE;
          sec.argument_count = cur_d;
          ph_d  = PhLength;
          cnt_d = '0;
          sh_d  = '0;
          fl_d  = '0;
          bp_d  = '0;
          ar_d  = '0;
          cur_d = '0;
          abl_d = '0;
        end else begin
          sec.kind = KIND_ERROR;
          sec.error_code = ERR_TRAILING;
          ph_d = PhHalt;
        end
      end else if (room_left < 13'd4) begin
        sec_v = 1'b1;
        sec.kind = KIND_ERROR;
        sec.error_code = ERR_OVERRUN;
        ph_d = PhHalt;
      end else begin
        ph_d = PhArglen;
      end
    end

    res_o = '0;
    if (prim_v) begin
      res_o.r0 = prim;
      res_o.r1 = sec;
      res_o.num = sec_v ? 2'd2 : 2'd1;
      if (sec_v) begin
        res_o.r1.last_of_run = 1'b1;
      end else begin
        res_o.r0.last_of_run = 1'b1;
      end
    end else if (sec_v) begin
      res_o.r0 = sec;
      res_o.r0.last_of_run = 1'b1;
      res_o.num = 2'd1;
    end
    if (!take_i) begin
      res_o.num = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PhLength;
      cnt_q <= '0;
      sh_q  <= '0;
      fl_q  <= '0;
      bp_q  <= '0;
      ar_q  <= '0;
      cur_q <= '0;
      abl_q <= '0;
    end else if (take_i) begin
      ph_q  <= ph_d;
      cnt_q <= cnt_d;
      sh_q  <= sh_d;
      fl_q  <= fl_d;
      bp_q  <= bp_d;
      ar_q  <= ar_d;
      cur_q <= cur_d;
      abl_q <= abl_d;
    end
  end

endmodule

`default_nettype wire

### hdl/lprd_res_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module lprd_res_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lprd_pkg::res_pair_t push_i,
  output logic                     room_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output lprd_pkg::res_t           out_res_o,
  output logic [$clog2(lprd_pkg::ResDepth):0] count_o
);
  import lprd_pkg::*;

  localparam int PtrW = $clog2(ResDepth);

  res_t            mem [ResDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            pop;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem[rd_q];
  // room for a full pair of results
  assign room_o      = (cnt_q <= (PtrW+1)'(ResDepth - 2));
  assign count_o     = cnt_q;

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.num);
    rd_d  = rd_q + PtrW'(pop);
    cnt_d = cnt_q + (PtrW+1)'(push_i.num) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem[wr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem[wr_q + 1'b1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### hdl/length_prefixed_request_deframer.sv
// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------
// in       | in_valid_i / in_stall_o    | in_req_i  (req_t)
// out      | out_valid_o / out_stall_i  | out_res_o (res_t)
// config   | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//
// A request is registered on entry and parsed from that register once the
// queue has room; its 0 to 2 results land in a 4-entry result queue and
// reach the output from there. One request per cycle is taken while the
// queue has room for two results; sustained rate is set by the output side
// at one result per cycle while out_stall_i is low. Reset clears parse state
// and the queue and loads the limit registers with 4096 and 1024.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_request_deframer #(
  parameter int MAX_FRAME_BYTES = 4096,
  parameter int MAX_ARGUMENTS   = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire lprd_pkg::req_t              in_req_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output lprd_pkg::res_t                   out_res_o,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [lprd_pkg::FrameW-1:0] cfg_wdata_i
);
  import lprd_pkg::*;

  localparam logic [16:0] MaxFrameK = 17'(MAX_FRAME_BYTES);
  localparam logic [12:0] MaxArgsK  = 13'(MAX_ARGUMENTS);

  logic [FrameW-1:0] max_frame_q;
  logic [ArgW-1:0]   max_args_q;
  logic [FrameW-1:0] lim_frame;
  logic [ArgW-1:0]   lim_args;

  logic      in_valid_q;
  req_t      in_req_q;
  logic      room;
  logic      take;
  res_pair_t pair;
  logic [$clog2(ResDepth):0] fifo_count;

  assign lim_frame = ({4'd0, max_frame_q} < MaxFrameK) ? max_frame_q
                                                       : MaxFrameK[FrameW-1:0];
  assign lim_args  = ({2'd0, max_args_q} < MaxArgsK) ? max_args_q
                                                     : MaxArgsK[ArgW-1:0];

  assign take       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= MaxFrameReset;
      max_args_q  <= MaxArgsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxFrame: max_frame_q <= cfg_wdata_i;
        CfgMaxArgs:  max_args_q  <= cfg_wdata_i[ArgW-1:0];
        default:     max_frame_q <= max_frame_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_req_q <= in_req_i;
    end
  end

  lprd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .req_i       (in_req_q),
    .lim_frame_i (lim_frame),
    .lim_args_i  (lim_args),
    .res_o       (pair)
  );

  lprd_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (pair),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .count_o     (fifo_count)
  );

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= ($clog2(ResDepth)+1)'(ResDepth))
    else $error("result queue overfilled");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pair.num != 2'd0) |-> room)
    else $error("results pushed without queue room");

  a_held_request_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q)
    else $error("stalled request lost from input register");

  a_pair_has_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pair.num == 2'd2) |-> (pair.r1.last_of_run && !pair.r0.last_of_run))
    else $error("last_of_run misplaced in result pair");

endmodule

`default_nettype wire
